// ===== rtl/rf_packet_crc_validator_unit_assert.svh =====
// assertion macros for the packet crc validator
`ifndef RF_PACKET_CRC_VALIDATOR_UNIT_ASSERT_SVH
`define RF_PACKET_CRC_VALIDATOR_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RFPCV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define RFPCV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rfpcv_pkg.sv =====
// shared constants, types and the crc byte update for the packet crc validator
package rfpcv_pkg;

  localparam int PACKET_BYTES = 24;
  localparam int POS_W        = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

  localparam logic [POS_W-1:0] POS_TYPE        = 5'd1;
  localparam logic [POS_W-1:0] POS_LEN         = 5'd2;
  localparam logic [POS_W-1:0] POS_HDR_CRC_END = 5'd5;
  localparam logic [POS_W-1:0] POS_SW_CRC_HI   = 5'd6;
  localparam logic [POS_W-1:0] POS_TY_CRC_HI   = 5'd7;
  localparam logic [POS_W-1:0] POS_PAYLOAD_BEG = 5'd9;

  localparam logic [7:0]  MSG_TYPE_1 = 8'h01;
  localparam logic [7:0]  MSG_TYPE_2 = 8'h02;
  localparam logic [7:0]  MSG_TYPE_4 = 8'h04;
  localparam logic [7:0]  MIN_TYPED_LEN = 8'd8;
  localparam logic [7:0]  MAX_LEN_EXCL  = 8'(PACKET_BYTES);
  localparam logic [4:0]  SWITCH_LEN    = 5'd7;

  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [7:0]  LEAD_RESET     = 8'h23;
  localparam logic [15:0] CRC_INIT_RESET = 16'h1D0F;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_INIT  = 2'd1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_BAD_LEN  = 2'd2;
  localparam logic [1:0] ST_CRC_ERR  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_word_t;

  typedef struct packed {
    logic [15:0] computed_crc;
    logic [1:0]  status;
    logic        packet_kind;
    logic [4:0]  effective_length;
    logic        valid_res;
  } verdict_t;

  // msb-first crc-16 over one byte, no reflection
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== rtl/rfpcv_in_stage.sv =====
// input register stage holding one accepted byte word
module rfpcv_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rfpcv_pkg::in_word_t in_word,
  output logic              held_valid,
  output rfpcv_pkg::in_word_t held_word,
  input  logic              take
);

  // no word is taken while reset is held
  assign in_ready = !rst && (!held_valid || take);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_word <= in_word;
    end
  end

endmodule

// ===== rtl/rfpcv_checker.sv =====
// per-byte packet state, crc accumulation and verdict logic
module rfpcv_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  rfpcv_pkg::in_word_t word,
  input  logic [7:0]          lead_byte,
  input  logic [15:0]         crc_initial_value,
  output logic                last,
  output rfpcv_pkg::verdict_t verdict
);

  logic [rfpcv_pkg::POS_W-1:0] byte_position, byte_position_next;
  logic [15:0] running_crc, running_crc_next;
  logic        typed_message, typed_message_next;
  logic [7:0]  declared_length, declared_length_next;
  logic [15:0] received_crc, received_crc_next;
  logic        lead_ok, lead_ok_next;

  logic [rfpcv_pkg::POS_W-1:0] pos;
  logic [rfpcv_pkg::POS_W-1:0] crc_hi_pos;
  logic [7:0]  b;
  logic        in_crc;
  logic        bad_len;
  logic [1:0]  status;
  logic [4:0]  len;

  assign b   = word.data_byte;
  assign pos = word.packet_start ? '0 : byte_position;

  always_comb begin
    lead_ok_next         = lead_ok;
    running_crc_next     = running_crc;
    typed_message_next   = typed_message;
    declared_length_next = declared_length;
    received_crc_next    = received_crc;
    in_crc               = 1'b0;
    crc_hi_pos           = rfpcv_pkg::POS_SW_CRC_HI;
    if (pos == '0) begin
      lead_ok_next         = (b == lead_byte);
      running_crc_next     = crc_initial_value;
      typed_message_next   = 1'b0;
      declared_length_next = '0;
      received_crc_next    = '0;
    end else begin
      if (pos == rfpcv_pkg::POS_TYPE) begin
        typed_message_next = (b == rfpcv_pkg::MSG_TYPE_1) || (b == rfpcv_pkg::MSG_TYPE_2) ||
                             (b == rfpcv_pkg::MSG_TYPE_4);
      end
      if (pos == rfpcv_pkg::POS_LEN) begin
        declared_length_next = b;
      end
      in_crc = (pos <= rfpcv_pkg::POS_HDR_CRC_END) ||
               (typed_message_next && (pos >= rfpcv_pkg::POS_PAYLOAD_BEG) &&
                ({3'b000, pos} <= declared_length_next));
      if (in_crc) begin
        running_crc_next = rfpcv_pkg::crc_add(running_crc, b);
      end
      crc_hi_pos = typed_message_next ? rfpcv_pkg::POS_TY_CRC_HI : rfpcv_pkg::POS_SW_CRC_HI;
      if (pos == crc_hi_pos) begin
        received_crc_next = {b, 8'h00};
      end else if (pos == crc_hi_pos + 5'd1) begin
        received_crc_next = {received_crc[15:8], b};
      end
    end
  end

  assign last               = (pos == rfpcv_pkg::LAST_POS);
  assign byte_position_next = last ? '0 : pos + 5'd1;

  // lead byte first, then length, then crc
  assign bad_len = typed_message_next &&
                   ((declared_length_next < rfpcv_pkg::MIN_TYPED_LEN) ||
                    (declared_length_next >= rfpcv_pkg::MAX_LEN_EXCL));
  assign len = typed_message_next ? declared_length_next[4:0] : rfpcv_pkg::SWITCH_LEN;

  always_comb begin
    if (!lead_ok_next) begin
      status = rfpcv_pkg::ST_BAD_LEAD;
    end else if (bad_len) begin
      status = rfpcv_pkg::ST_BAD_LEN;
    end else if (running_crc_next != received_crc_next) begin
      status = rfpcv_pkg::ST_CRC_ERR;
    end else begin
      status = rfpcv_pkg::ST_OK;
    end
  end

  assign verdict.computed_crc     = running_crc_next;
  assign verdict.status           = status;
  assign verdict.packet_kind      = typed_message_next;
  assign verdict.valid_res        = (status == rfpcv_pkg::ST_OK);
  assign verdict.effective_length = (status == rfpcv_pkg::ST_OK) ? len : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      running_crc     <= rfpcv_pkg::CRC_INIT_RESET;
      typed_message   <= 1'b0;
      declared_length <= '0;
      received_crc    <= '0;
      lead_ok         <= 1'b0;
    end else if (step) begin
      byte_position   <= byte_position_next;
      running_crc     <= running_crc_next;
      typed_message   <= typed_message_next;
      declared_length <= declared_length_next;
      received_crc    <= received_crc_next;
      lead_ok         <= lead_ok_next;
    end
  end

endmodule

// ===== rtl/rf_packet_crc_validator_unit.sv =====
// top level of the radio packet crc-16 validator
// the last byte of a packet is held in the input register, then its verdict is loaded into the result register
// throughput: one byte word per cycle; a stalled verdict word holds back only the last byte
// of the next packet
// reset (rst, synchronous): byte position to zero, lead byte 0x23, crc initial value 0x1d0f,
// no word held in either register, both ready outputs low
module rf_packet_crc_validator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // packet_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // valid_res, effective_length[4:0], status[1:0],
                                      // computed_crc[15:0]
  output logic        m_axis_tuser,   // packet_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [rfpcv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  `include "rf_packet_crc_validator_unit_assert.svh"

  logic [7:0]  lead_byte;
  logic [15:0] crc_initial_value;

  rfpcv_pkg::in_word_t in_word, held_word;
  rfpcv_pkg::verdict_t verdict, out_word;
  logic held_valid;
  logic step;
  logic last;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_byte         <= rfpcv_pkg::LEAD_RESET;
      crc_initial_value <= rfpcv_pkg::CRC_INIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rfpcv_pkg::CFG_LEAD_BYTE: lead_byte         <= cfg_data[7:0];
        rfpcv_pkg::CFG_CRC_INIT:  crc_initial_value <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_word.data_byte    = s_axis_tdata;
  assign in_word.packet_start = s_axis_tuser;

  // only a last byte has to wait for the result register to be free or draining
  assign step = held_valid && (!last || !m_axis_tvalid || m_axis_tready);

  rfpcv_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_word    (in_word),
    .held_valid (held_valid),
    .held_word  (held_word),
    .take       (step)
  );

  rfpcv_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .step              (step),
    .word              (held_word),
    .lead_byte         (lead_byte),
    .crc_initial_value (crc_initial_value),
    .last              (last),
    .verdict           (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= step && last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && last) begin
      out_word <= verdict;
    end
  end

  assign m_axis_tdata = {out_word.computed_crc, out_word.status, out_word.effective_length,
                         out_word.valid_res};
  assign m_axis_tuser = out_word.packet_kind;

  `RFPCV_ASSERT_NEXT(a_last_gives_verdict, step && last, m_axis_tvalid,
    "last byte of a packet did not load a verdict word")
  `RFPCV_ASSERT_NEXT(a_held_word_kept, held_valid && !step, held_valid,
    "input register dropped a word that was not processed")
  `RFPCV_ASSERT_NOW(a_ok_switch_len,
    m_axis_tvalid && !out_word.packet_kind && (out_word.status == rfpcv_pkg::ST_OK),
    out_word.effective_length == rfpcv_pkg::SWITCH_LEN,
    "valid switch packet reported a length other than seven")
  `RFPCV_ASSERT_NOW(a_bad_len_typed_only,
    m_axis_tvalid && (out_word.status == rfpcv_pkg::ST_BAD_LEN),
    out_word.packet_kind && (out_word.effective_length == 5'd0),
    "bad length reported for a switch packet or with a length")

endmodule

// ===== tb/rf_packet_crc_validator_checker.sv =====
// verdict predictor and scoreboard for the packet crc validator, fed from its stream ports
module rf_packet_crc_validator_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [rfpcv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned mismatches,
  output int unsigned verdicts_due,
  output int unsigned n_ok,
  output int unsigned n_bad_lead,
  output int unsigned n_bad_len,
  output int unsigned n_crc_err
);
  timeunit 1ns;
  timeprecision 1ps;
  import rfpcv_pkg::*;

  // register copies and per-packet tracking
  logic [7:0]  lead_cfg;
  logic [15:0] crc_seed_cfg;
  logic [4:0]  pos;
  logic [15:0] crc_acc;
  logic        typed;
  logic [7:0]  decl_len;
  logic [15:0] rx_crc;
  logic        lead_match;

  verdict_t    verdict_q[$];
  int unsigned err_cnt = 0;
  int unsigned seen [4] = '{0, 0, 0, 0};

  // bit-serial form of the ccitt polynomial, msb first
  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  task automatic take_byte(input logic [7:0] b, input logic first);
    logic [4:0] p;
    logic [4:0] hi;
    logic [7:0] len;
    logic [1:0] st;
    verdict_t   v;
    p = first ? 5'd0 : pos;
    if (p == 5'd0) begin
      lead_match = (b == lead_cfg);
      crc_acc    = crc_seed_cfg;
      typed      = 1'b0;
      decl_len   = 8'd0;
      rx_crc     = 16'd0;
    end else begin
      if (p == POS_TYPE) typed = (b == MSG_TYPE_1) || (b == MSG_TYPE_2) || (b == MSG_TYPE_4);
      if (p == POS_LEN) decl_len = b;
      if (p <= POS_HDR_CRC_END || (typed && p >= POS_PAYLOAD_BEG && {3'b000, p} <= decl_len))
        crc_acc = crc_next(crc_acc, b);
      hi = typed ? POS_TY_CRC_HI : POS_SW_CRC_HI;
      if (p == hi) rx_crc = {b, 8'h00};
      else if (p == hi + 5'd1) rx_crc = rx_crc | {8'h00, b};
    end
    if (p == LAST_POS) begin
      len = typed ? decl_len : {3'b000, SWITCH_LEN};
      // lead byte beats length, length beats crc
      if (!lead_match) st = ST_BAD_LEAD;
      else if (typed && (len < MIN_TYPED_LEN || len >= MAX_LEN_EXCL)) st = ST_BAD_LEN;
      else if (crc_acc != rx_crc) st = ST_CRC_ERR;
      else st = ST_OK;
      v.valid_res        = (st == ST_OK);
      v.effective_length = (st == ST_OK) ? len[4:0] : 5'd0;
      v.packet_kind      = typed;
      v.status           = st;
      v.computed_crc     = crc_acc;
      verdict_q.push_back(v);
      pos = 5'd0;
    end else begin
      pos = p + 5'd1;
    end
  endtask

  task automatic note_mismatch(input string field, input logic [15:0] want, input logic [15:0] got);
    err_cnt++;
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  task automatic check_verdict();
    verdict_t e;
    if (verdict_q.size() == 0) begin
      err_cnt++;
      $display("%0t ns: verdict word with none expected, expected nothing, actual %h/%b",
               $time, m_axis_tdata, m_axis_tuser);
    end else begin
      e = verdict_q.pop_front();
      seen[e.status]++;
      if (m_axis_tdata[0] !== e.valid_res)
        note_mismatch("valid_res", 16'(e.valid_res), 16'(m_axis_tdata[0]));
      if (m_axis_tdata[5:1] !== e.effective_length)
        note_mismatch("effective_length", 16'(e.effective_length), 16'(m_axis_tdata[5:1]));
      if (m_axis_tuser !== e.packet_kind)
        note_mismatch("packet_kind", 16'(e.packet_kind), 16'(m_axis_tuser));
      if (m_axis_tdata[7:6] !== e.status)
        note_mismatch("status", 16'(e.status), 16'(m_axis_tdata[7:6]));
      if (m_axis_tdata[23:8] !== e.computed_crc)
        note_mismatch("computed_crc", e.computed_crc, m_axis_tdata[23:8]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      lead_cfg     = LEAD_RESET;
      crc_seed_cfg = CRC_INIT_RESET;
      pos          = 5'd0;
      crc_acc      = CRC_INIT_RESET;
      typed        = 1'b0;
      decl_len     = 8'd0;
      rx_crc       = 16'd0;
      lead_match   = 1'b0;
      verdict_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LEAD_BYTE: lead_cfg = cfg_data[7:0];
          CFG_CRC_INIT:  crc_seed_cfg = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_byte(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) check_verdict();
    end
    mismatches   <= err_cnt;
    verdicts_due <= verdict_q.size();
    n_ok         <= seen[ST_OK];
    n_bad_lead   <= seen[ST_BAD_LEAD];
    n_bad_len    <= seen[ST_BAD_LEN];
    n_crc_err    <= seen[ST_CRC_ERR];
  end

endmodule

// ===== tb/tb.sv =====
// top of the packet crc validator testbench: stimulus, back-pressure and final verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rfpcv_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned BYTE_TARGET   = 1200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LEAD_BYTE;
  logic [15:0] cfg_data = 16'd0;

  int unsigned mismatches, verdicts_due, n_ok, n_bad_lead, n_bad_len, n_crc_err;

  always #5 clk = ~clk;

  rf_packet_crc_validator_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rf_packet_crc_validator_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .verdicts_due(verdicts_due),
    .n_ok(n_ok), .n_bad_lead(n_bad_lead), .n_bad_len(n_bad_len), .n_crc_err(n_crc_err)
  );

  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d verdicts outstanding", cycle_count, verdicts_due);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // verdict-side back-pressure: random runs of ready and stall, or steady ready
  bit          rx_steady = 1'b0;
  int unsigned rx_hold = 0;
  always @(posedge clk) begin
    if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 1) == 1) begin
      m_axis_tready <= 1'b1;
      rx_hold <= $urandom_range(1, 30);
    end else begin
      m_axis_tready <= 1'b0;
      rx_hold <= ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
  end

  logic [7:0]  pkt [PACKET_BYTES];
  logic [7:0]  cur_lead = LEAD_RESET;
  logic [15:0] cur_seed = CRC_INIT_RESET;
  bit          tx_steady = 1'b0;
  bit          pkt_open = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned packets_sent = 0;
  int unsigned reconfigs = 0;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    repeat (8) c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] corner16(input logic [15:0] dflt);
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return dflt;
      default: return 16'($urandom);
    endcase
  endfunction

  // fills pkt with random content, then places header fields and the crc
  task automatic make_packet(input logic [7:0] lead, input logic [7:0] mtype,
                             input logic [7:0] len, input bit crc_good);
    logic [15:0] c;
    bit          typed;
    int          hi;
    typed = (mtype == MSG_TYPE_1) || (mtype == MSG_TYPE_2) || (mtype == MSG_TYPE_4);
    for (int k = 0; k < PACKET_BYTES; k++) pkt[k] = 8'($urandom);
    pkt[0] = lead;
    pkt[1] = mtype;
    if (typed) pkt[2] = len;
    c = cur_seed;
    for (int k = 1; k < PACKET_BYTES; k++)
      if (k <= POS_HDR_CRC_END || (typed && k >= POS_PAYLOAD_BEG && k <= len))
        c = crc_byte(c, pkt[k]);
    if (!crc_good) c = c ^ (16'd1 << $urandom_range(0, 15));
    hi = typed ? POS_TY_CRC_HI : POS_SW_CRC_HI;
    pkt[hi]     = c[15:8];
    pkt[hi + 1] = c[7:0];
  endtask

  task automatic push_byte(input logic [7:0] b, input logic first);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_bytes(input int lo, input int hi, input logic first);
    if (lo == 0) packets_sent++;
    for (int k = lo; k < hi; k++) push_byte(pkt[k], (k == 0) && first);
  endtask

  task automatic send_packet(input logic [7:0] lead, input logic [7:0] mtype,
                             input logic [7:0] len, input bit crc_good, input logic first);
    make_packet(lead, mtype, len, crc_good);
    send_bytes(0, PACKET_BYTES, first);
  endtask

  // hold the byte stream until every verdict is out and the pipeline has drained
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_LEAD_BYTE) cur_lead = val[7:0];
    else if (idx == CFG_CRC_INIT) cur_seed = val;
  endtask

  task automatic reconfigure(input logic [7:0] lead, input logic [15:0] seed);
    settle();
    // writes to unused indexes must change nothing
    if ($urandom_range(0, 3) == 0)
      write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_2 : CFG_SPARE_3, 16'($urandom));
    write_reg(CFG_LEAD_BYTE, {8'($urandom), lead});
    write_reg(CFG_CRC_INIT, seed);
    cfg_valid <= 1'b0;
    reconfigs++;
  endtask

  task automatic random_packet();
    logic [7:0]  lead, mtype, len;
    logic        first;
    int unsigned cut;
    lead = ($urandom_range(0, 99) < 90) ? cur_lead : 8'($urandom);
    if ($urandom_range(0, 99) < 70) begin
      case ($urandom_range(0, 2))
        0: mtype = MSG_TYPE_1;
        1: mtype = MSG_TYPE_2;
        default: mtype = MSG_TYPE_4;
      endcase
    end else begin
      mtype = 8'($urandom);
    end
    if ($urandom_range(0, 99) < 80) len = 8'($urandom_range(MIN_TYPED_LEN, PACKET_BYTES - 1));
    else if ($urandom_range(0, 1) == 1) len = 8'($urandom_range(0, MIN_TYPED_LEN - 1));
    else len = 8'($urandom_range(PACKET_BYTES, 255));
    make_packet(lead, mtype, len, $urandom_range(0, 99) < 85);
    // occasional pure noise
    if ($urandom_range(0, 99) < 4)
      for (int k = 0; k < PACKET_BYTES; k++) pkt[k] = 8'($urandom);
    // after a cut-short packet the next one has to be marked as a start
    first = pkt_open ? 1'b1 : ($urandom_range(0, 99) < 75);
    cut = ($urandom_range(0, 99) < 6) ? $urandom_range(1, PACKET_BYTES - 1) : PACKET_BYTES;
    send_bytes(0, cut, first);
    pkt_open = (cut != PACKET_BYTES);
  endtask

  initial begin
    logic [15:0] lead_pick;
    logic [15:0] seed_pick;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset register values, both lengths at the limits, back-to-back words
    rx_steady <= 1'b1;
    tx_steady = 1'b1;
    send_packet(cur_lead, MSG_TYPE_1, MIN_TYPED_LEN, 1'b1, 1'b1);
    send_packet(cur_lead, MSG_TYPE_2, 8'(PACKET_BYTES - 1), 1'b1, 1'b0);
    tx_steady = 1'b0;
    rx_steady <= 1'b0;
    send_packet(cur_lead, MSG_TYPE_4, 8'd15, 1'b1, 1'b1);
    send_packet(cur_lead, 8'h00, 8'd0, 1'b1, 1'b0);
    send_packet(cur_lead, 8'hFF, 8'd0, 1'b0, 1'b1);
    // bad length wins over a crc error
    send_packet(cur_lead, MSG_TYPE_1, 8'd7, 1'b0, 1'b1);
    send_packet(cur_lead, MSG_TYPE_2, MAX_LEN_EXCL, 1'b1, 1'b1);
    send_packet(cur_lead, MSG_TYPE_4, 8'hFF, 1'b1, 1'b1);
    // bad lead wins over everything
    send_packet(~cur_lead, MSG_TYPE_1, 8'd3, 1'b0, 1'b1);
    // restart in the middle of a packet
    make_packet(cur_lead, MSG_TYPE_1, 8'd10, 1'b1);
    send_bytes(0, 10, 1'b1);
    send_packet(cur_lead, MSG_TYPE_1, 8'd10, 1'b1, 1'b1);
    // registers rewritten mid-packet only take effect at the next start
    make_packet(cur_lead, MSG_TYPE_2, 8'd12, 1'b1);
    send_bytes(0, 5, 1'b1);
    reconfigure(8'h00, 16'hFFFF);
    send_bytes(5, PACKET_BYTES, 1'b0);
    send_packet(cur_lead, MSG_TYPE_1, 8'd20, 1'b1, 1'b0);
    reconfigure(8'hFF, 16'h0000);
    send_packet(cur_lead, 8'h03, 8'd0, 1'b1, 1'b1);
    settle();
    write_reg(CFG_SPARE_2, 16'hFFFF);
    write_reg(CFG_SPARE_3, 16'h0000);
    cfg_valid <= 1'b0;
    send_packet(cur_lead, MSG_TYPE_4, 8'd23, 1'b1, 1'b1);

    // random traffic, with periodic register changes
    while (bytes_sent < BYTE_TARGET) begin
      if (packets_sent % 10 == 9) begin
        lead_pick = corner16({8'h00, LEAD_RESET});
        seed_pick = corner16(CRC_INIT_RESET);
        reconfigure(lead_pick[7:0], seed_pick);
      end else if ($urandom_range(0, 99) < 3) begin
        settle();
      end
      if (packets_sent % 8 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady <= ($urandom_range(0, 3) == 0);
      end
      random_packet();
    end
    rx_steady <= 1'b0;
    settle();

    $display("%0d bytes in %0d packets; %0d verdicts: %0d ok, %0d bad lead, %0d bad length, %0d crc",
             bytes_sent, packets_sent, n_ok + n_bad_lead + n_bad_len + n_crc_err,
             n_ok, n_bad_lead, n_bad_len, n_crc_err);
    $display("lead byte and crc seed reloaded %0d times, restarts and unused indexes included",
             reconfigs);
    if (mismatches == 0 && verdicts_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
